// File: rtl/core/efs_pkg.sv
`default_nettype none

package efs_pkg;

  // Default coordinate width (signed Q12.4 at 16 bits).
  localparam int DEF_COORD_BITS = 16;

  // Width of the configuration register index.
  localparam int CFG_INDEX_BITS = 3;

  // Register stages between an accepted point and its result.
  localparam int PIPE_DEPTH = 5;

  // Configuration register map.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_CENTER_X     = 3'd0,
    REG_CENTER_Y     = 3'd1,
    REG_RADIUS_X     = 3'd2,
    REG_RADIUS_Y     = 3'd3,
    REG_STROKE_WIDTH = 3'd4
  } efs_reg_t;

  // Load enables of the five pipeline stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } efs_en_t;

endpackage

`default_nettype wire

// File: rtl/core/efs_ifs.sv
`default_nettype none

// Query point channel.
interface efs_point_if #(parameter int W = efs_pkg::DEF_COORD_BITS) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] point_x;
  logic signed [W-1:0] point_y;

  modport source (output valid, point_x, point_y, input ready);
  modport sink   (input valid, point_x, point_y, output ready);
endinterface

// Hit result channel.
interface efs_hit_if ();
  logic valid;
  logic ready;
  logic in_fill;
  logic in_stroke;

  modport source (output valid, in_fill, in_stroke, input ready);
  modport sink   (input valid, in_fill, in_stroke, output ready);
endinterface

// Configuration write channel.
interface efs_cfg_if #(parameter int W = efs_pkg::DEF_COORD_BITS) ();
  logic                                valid;
  logic                                ready;
  logic [efs_pkg::CFG_INDEX_BITS-1:0]  index;
  logic [W-1:0]                        data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/ellipse_fill_stroke_hit_test.sv
`default_nettype none

// Channel  Dir  Payload                           Beat taken when
// -------  ---  --------------------------------  -----------------------
// point    in   point_x, point_y (signed Q12.4)   point.valid & point.ready
// hit      out  in_fill, in_stroke                hit.valid & hit.ready
// cfg      in   index, data                       cfg.valid (ready tied high)
//
// One point per cycle sustained while hit is ready; a result is offered once its
// point has passed one register stage each for magnitudes, squares, partial
// products, products, and the final compare.
// Reset clears all valid bits and the configuration registers to zero.
// A full stage holds while its successor is not loading, so a stall on hit
// backs up only as far as the first empty stage; bubbles are squeezed out.
module ellipse_fill_stroke_hit_test #(
  parameter int COORD_BITS = efs_pkg::DEF_COORD_BITS
) (
  input  logic        clk,
  input  logic        rst,
  efs_point_if.sink   point,
  efs_hit_if.source   hit,
  efs_cfg_if.sink     cfg
);
  import efs_pkg::*;

  localparam int W = COORD_BITS;
  localparam int N = 2 * W + 3;

  // Configuration registers.
  logic signed [W-1:0] center_x;
  logic signed [W-1:0] center_y;
  logic signed [W-1:0] radius_x;
  logic signed [W-1:0] radius_y;
  logic        [W-1:0] stroke_width;

  // Pipeline control.
  efs_en_t en;
  logic    vld1;
  logic    vld2;
  logic    vld3;
  logic    vld4;
  logic    vld5;

  // Stage 2 outputs of the front end.
  logic [N-1:0] dxs;
  logic [N-1:0] dys;
  logic [N-1:0] fas;
  logic [N-1:0] fbs;
  logic [N-1:0] ias;
  logic [N-1:0] ibs;
  logic [N-1:0] oas;
  logic [N-1:0] obs;
  logic         rad_ok2;

  // Degenerate inner ellipse handling.
  logic spec_c;
  logic specv_c;
  logic rad_ok3;
  logic spec3;
  logic specv3;
  logic rad_ok4;
  logic spec4;
  logic specv4;

  logic fill_le;
  logic inner_le;
  logic outer_le;
  logic outside_inner;

  logic in_fill;
  logic in_stroke;

  // Configuration writes.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x     <= '0;
      center_y     <= '0;
      radius_x     <= '0;
      radius_y     <= '0;
      stroke_width <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (efs_reg_t'(cfg.index))
        REG_CENTER_X:     center_x     <= $signed(cfg.data);
        REG_CENTER_Y:     center_y     <= $signed(cfg.data);
        REG_RADIUS_X:     radius_x     <= $signed(cfg.data);
        REG_RADIUS_Y:     radius_y     <= $signed(cfg.data);
        REG_STROKE_WIDTH: stroke_width <= cfg.data;
        default: ;
      endcase
    end
  end

  // A stage may load when it is empty or its successor is loading.
  always_comb begin
    en.s5 = !vld5 || hit.ready;
    en.s4 = !vld4 || en.s5;
    en.s3 = !vld3 || en.s4;
    en.s2 = !vld2 || en.s3;
    en.s1 = !vld1 || en.s2;
  end

  assign point.ready = en.s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
      vld4 <= 1'b0;
      vld5 <= 1'b0;
    end else begin
      if (en.s1) vld1 <= point.valid;
      if (en.s2) vld2 <= vld1;
      if (en.s3) vld3 <= vld2;
      if (en.s4) vld4 <= vld3;
      if (en.s5) vld5 <= vld4;
    end
  end

  efs_front #(.W(W)) u_front (
    .clk          (clk),
    .en           (en),
    .point_x      (point.point_x),
    .point_y      (point.point_y),
    .center_x     (center_x),
    .center_y     (center_y),
    .radius_x     (radius_x),
    .radius_y     (radius_y),
    .stroke_width (stroke_width),
    .dxs          (dxs),
    .dys          (dys),
    .fas          (fas),
    .fbs          (fbs),
    .ias          (ias),
    .ibs          (ibs),
    .oas          (oas),
    .obs          (obs),
    .rad_ok       (rad_ok2)
  );

  // A zero inner radius collapses the inner ellipse to a point or a segment.
  always_comb begin
    spec_c  = (ias == '0) || (ibs == '0);
    specv_c = 1'b0;
    priority if ((ias == '0) && (ibs == '0)) begin
      specv_c = (dxs != '0) || (dys != '0);
    end else if (ias == '0) begin
      specv_c = (dxs != '0) || (dys > ibs);
    end else if (ibs == '0) begin
      specv_c = (dys != '0) || (dxs > ias);
    end else begin
      specv_c = 1'b0;
    end
  end

  // Side flags ride along with the products through stages 3 and 4.
  always_ff @(posedge clk) begin
    if (en.s3) begin
      rad_ok3 <= rad_ok2;
      spec3   <= spec_c;
      specv3  <= specv_c;
    end
    if (en.s4) begin
      rad_ok4 <= rad_ok3;
      spec4   <= spec3;
      specv4  <= specv3;
    end
  end

  efs_ecmp #(.N(N)) u_fill (
    .clk(clk), .en(en), .dxs(dxs), .dys(dys), .asq(fas), .bsq(fbs), .le(fill_le)
  );

  efs_ecmp #(.N(N)) u_inner (
    .clk(clk), .en(en), .dxs(dxs), .dys(dys), .asq(ias), .bsq(ibs), .le(inner_le)
  );

  efs_ecmp #(.N(N)) u_outer (
    .clk(clk), .en(en), .dxs(dxs), .dys(dys), .asq(oas), .bsq(obs), .le(outer_le)
  );

  assign outside_inner = spec4 ? specv4 : !inner_le;

  // Stage 5: output register.
  always_ff @(posedge clk) begin
    if (en.s5) begin
      in_fill   <= rad_ok4 && fill_le;
      in_stroke <= rad_ok4 && outside_inner && outer_le;
    end
  end

  assign hit.valid     = vld5;
  assign hit.in_fill   = in_fill;
  assign hit.in_stroke = in_stroke;

endmodule

`default_nettype wire

// File: rtl/core/efs_front.sv
`default_nettype none

// Stages 1 and 2: doubled offsets and radii, their magnitudes, then squares.
module efs_front #(
  parameter int W = efs_pkg::DEF_COORD_BITS
) (
  input  logic                   clk,
  input  efs_pkg::efs_en_t       en,
  input  logic signed [W-1:0]    point_x,
  input  logic signed [W-1:0]    point_y,
  input  logic signed [W-1:0]    center_x,
  input  logic signed [W-1:0]    center_y,
  input  logic signed [W-1:0]    radius_x,
  input  logic signed [W-1:0]    radius_y,
  input  logic        [W-1:0]    stroke_width,
  output logic        [2*W+2:0]  dxs,
  output logic        [2*W+2:0]  dys,
  output logic        [2*W+2:0]  fas,
  output logic        [2*W+2:0]  fbs,
  output logic        [2*W+2:0]  ias,
  output logic        [2*W+2:0]  ibs,
  output logic        [2*W+2:0]  oas,
  output logic        [2*W+2:0]  obs,
  output logic                   rad_ok
);
  import efs_pkg::*;

  localparam int NV   = 8;
  localparam int M_DX = 0;
  localparam int M_DY = 1;
  localparam int M_FA = 2;
  localparam int M_FB = 3;
  localparam int M_IA = 4;
  localparam int M_IB = 5;
  localparam int M_OA = 6;
  localparam int M_OB = 7;

  function automatic logic [W+1:0] mag_of(input logic signed [W+1:0] v);
    mag_of = v[W+1] ? (W+2)'(-v) : (W+2)'(v);
  endfunction

  function automatic logic [2*W+2:0] sq_of(input logic [W+1:0] m);
    logic [2*W+3:0] full;
    full  = (2*W+4)'(m) * (2*W+4)'(m);
    sq_of = full[2*W+2:0];
  endfunction

  logic signed [W:0]   dx;
  logic signed [W:0]   dy;
  logic signed [W+1:0] dx2;
  logic signed [W+1:0] dy2;
  logic signed [W+1:0] r2x;
  logic signed [W+1:0] r2y;
  logic signed [W+1:0] swe;
  logic                rad_ok_c;

  logic [NV-1:0][W+1:0]   mag_c;
  logic [NV-1:0][W+1:0]   mag;
  logic                   rad_ok1;
  logic [NV-1:0][2*W+2:0] sq;

  // Doubled offsets from the center and doubled fill, inner and outer radii.
  always_comb begin
    dx  = $signed({point_x[W-1], point_x}) - $signed({center_x[W-1], center_x});
    dy  = $signed({point_y[W-1], point_y}) - $signed({center_y[W-1], center_y});
    dx2 = {dx, 1'b0};
    dy2 = {dy, 1'b0};
    r2x = {radius_x[W-1], radius_x, 1'b0};
    r2y = {radius_y[W-1], radius_y, 1'b0};
    swe = {2'b00, stroke_width};

    mag_c[M_DX] = mag_of(dx2);
    mag_c[M_DY] = mag_of(dy2);
    mag_c[M_FA] = mag_of(r2x);
    mag_c[M_FB] = mag_of(r2y);
    mag_c[M_IA] = mag_of(r2x - swe);
    mag_c[M_IB] = mag_of(r2y - swe);
    mag_c[M_OA] = mag_of(r2x + swe);
    mag_c[M_OB] = mag_of(r2y + swe);

    rad_ok_c = !radius_x[W-1] && (radius_x != '0) && !radius_y[W-1] && (radius_y != '0);
  end

  // Stage 1 register.
  always_ff @(posedge clk) begin
    if (en.s1) begin
      mag     <= mag_c;
      rad_ok1 <= rad_ok_c;
    end
  end

  // Stage 2 register: all eight squares.
  always_ff @(posedge clk) begin
    if (en.s2) begin
      for (int i = 0; i < NV; i++) begin
        sq[i] <= sq_of(mag[i]);
      end
      rad_ok <= rad_ok1;
    end
  end

  assign dxs = sq[M_DX];
  assign dys = sq[M_DY];
  assign fas = sq[M_FA];
  assign fbs = sq[M_FB];
  assign ias = sq[M_IA];
  assign ibs = sq[M_IB];
  assign oas = sq[M_OA];
  assign obs = sq[M_OB];

endmodule

`default_nettype wire

// File: rtl/core/efs_wmul.sv
`default_nettype none

// Wide unsigned multiply split into four half-width partial products.
// Stage 3 registers the partial products, stage 4 the assembled product.
module efs_wmul #(
  parameter int N = 2 * efs_pkg::DEF_COORD_BITS + 3
) (
  input  logic             clk,
  input  efs_pkg::efs_en_t en,
  input  logic [N-1:0]     a,
  input  logic [N-1:0]     b,
  output logic [2*N-1:0]   prod
);
  import efs_pkg::*;

  localparam int H  = (N + 1) / 2;
  localparam int L  = N - H;
  localparam int PW = 2 * N;

  logic [2*H-1:0] pp_ll;
  logic [H+L-1:0] pp_lh;
  logic [H+L-1:0] pp_hl;
  logic [2*L-1:0] pp_hh;
  logic [PW-1:0]  sum;

  // Partial products.
  always_ff @(posedge clk) begin
    if (en.s3) begin
      pp_ll <= (2*H)'(a[H-1:0]) * (2*H)'(b[H-1:0]);
      pp_lh <= (H+L)'(a[H-1:0]) * (H+L)'(b[N-1:H]);
      pp_hl <= (H+L)'(a[N-1:H]) * (H+L)'(b[H-1:0]);
      pp_hh <= (2*L)'(a[N-1:H]) * (2*L)'(b[N-1:H]);
    end
  end

  // Reassemble; the full product always fits in 2N bits.
  always_comb begin
    sum = PW'(pp_ll) + (PW'(pp_lh) << H) + (PW'(pp_hl) << H) + (PW'(pp_hh) << (2*H));
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      prod <= sum;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/efs_ecmp.sv
`default_nettype none

// Ellipse test without division: dx^2*b^2 + dy^2*a^2 <= a^2*b^2.
// Products are registered in stages 3 and 4; the compare is combinational
// from the stage 4 registers.
module efs_ecmp #(
  parameter int N = 2 * efs_pkg::DEF_COORD_BITS + 3
) (
  input  logic             clk,
  input  efs_pkg::efs_en_t en,
  input  logic [N-1:0]     dxs,
  input  logic [N-1:0]     dys,
  input  logic [N-1:0]     asq,
  input  logic [N-1:0]     bsq,
  output logic             le
);
  import efs_pkg::*;

  logic [2*N-1:0] p_xb;
  logic [2*N-1:0] p_ya;
  logic [2*N-1:0] p_ab;
  logic [2*N:0]   lhs;

  efs_wmul #(.N(N)) u_xb (.clk(clk), .en(en), .a(dxs), .b(bsq), .prod(p_xb));
  efs_wmul #(.N(N)) u_ya (.clk(clk), .en(en), .a(dys), .b(asq), .prod(p_ya));
  efs_wmul #(.N(N)) u_ab (.clk(clk), .en(en), .a(asq), .b(bsq), .prod(p_ab));

  // One wide add and one compare.
  always_comb begin
    lhs = {1'b0, p_xb} + {1'b0, p_ya};
    le  = (lhs <= {1'b0, p_ab});
  end

endmodule

`default_nettype wire

// File: rtl/core/efs_chk.sv
`default_nettype none

// Port-level checks for the ellipse hit tester.
module efs_chk #(
  parameter int W = efs_pkg::DEF_COORD_BITS
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               point_valid,
  input logic                               point_ready,
  input logic                               hit_valid,
  input logic                               hit_ready,
  input logic                               hit_in_fill,
  input logic                               hit_in_stroke,
  input logic                               cfg_valid,
  input logic                               cfg_ready,
  input logic [efs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input logic [W-1:0]                       cfg_data
);
  import efs_pkg::*;

  localparam int OCC_BITS = $clog2(PIPE_DEPTH + 1);

  logic                rx_ok;
  logic                ry_ok;
  logic                sw_nz;
  logic                data_pos;
  logic [OCC_BITS-1:0] occ;
  logic [OCC_BITS-1:0] occ_next;

  assign data_pos = !cfg_data[W-1] && (cfg_data != '0);

  // Shadow of whether each radius is positive and whether any stroke is configured.
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_ok <= 1'b0;
      ry_ok <= 1'b0;
      sw_nz <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_RADIUS_X)     rx_ok <= data_pos;
      if (cfg_index == REG_RADIUS_Y)     ry_ok <= data_pos;
      if (cfg_index == REG_STROKE_WIDTH) sw_nz <= (cfg_data != '0);
    end
  end

  // Points in flight.
  always_comb begin
    occ_next = occ + OCC_BITS'(point_valid && point_ready) - OCC_BITS'(hit_valid && hit_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ_next;
    end
  end

  // A result that is not taken stays offered.
  a_hit_hold: assert property (@(posedge clk) disable iff (rst)
    hit_valid && !hit_ready |=> hit_valid)
    else $error("result beat dropped while stalled");

  // A non-positive radius disables both flags.
  a_bad_radius: assert property (@(posedge clk) disable iff (rst)
    hit_valid && !(rx_ok && ry_ok) |-> !hit_in_fill && !hit_in_stroke)
    else $error("hit reported with a non-positive radius");

  // With no stroke the inner and outer ellipses coincide, leaving an empty ring.
  a_no_stroke: assert property (@(posedge clk) disable iff (rst)
    hit_valid && !sw_nz |-> !hit_in_stroke)
    else $error("stroke hit with zero stroke width");

  // Every result has a point behind it, and the pipe never holds more than its depth.
  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    (occ <= OCC_BITS'(PIPE_DEPTH)) && (!hit_valid || (occ != '0)))
    else $error("result count out of step with accepted points");

endmodule

bind ellipse_fill_stroke_hit_test efs_chk #(.W(COORD_BITS)) u_efs_chk (
  .clk           (clk),
  .rst           (rst),
  .point_valid   (point.valid),
  .point_ready   (point.ready),
  .hit_valid     (hit.valid),
  .hit_ready     (hit.ready),
  .hit_in_fill   (hit.in_fill),
  .hit_in_stroke (hit.in_stroke),
  .cfg_valid     (cfg.valid),
  .cfg_ready     (cfg.ready),
  .cfg_index     (cfg.index),
  .cfg_data      (cfg.data)
);

`default_nettype wire
